[rtl/core/efm_pkg.sv]
// Shared types and constants for the estimator variance failsafe monitor.
package efm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD     = 2'd0;
    localparam logic [1:0] CFG_RESPONSE      = 2'd1;
    localparam logic [1:0] CFG_FAIL_LIMIT    = 2'd2;
    localparam logic [1:0] CFG_WARN_INTERVAL = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_THRESHOLD     = 16'd205;
    localparam logic [31:0] RST_THR_SQ        = 32'd42025;
    localparam logic [1:0]  RST_RESPONSE      = 2'd2;
    localparam logic [7:0]  RST_FAIL_LIMIT    = 8'd10;
    localparam logic [31:0] RST_WARN_INTERVAL = 32'd30000;

    // Failsafe response setting
    localparam logic [1:0] FS_RESP_NONE   = 2'd0;
    localparam logic [1:0] FS_RESP_REPORT = 2'd1;
    localparam logic [1:0] FS_RESP_HOLD   = 2'd2;
    // Unassigned setting; behaves as hold
    localparam logic [1:0] FS_RESP_SPARE  = 2'd3;

    // Failsafe change codes
    localparam logic [1:0] CHG_NONE  = 2'd0;
    localparam logic [1:0] CHG_ENTER = 2'd1;
    localparam logic [1:0] CHG_CLEAR = 2'd2;

    // Response taken codes
    localparam logic [1:0] RESP_NONE   = 2'd0;
    localparam logic [1:0] RESP_REPORT = 2'd1;
    localparam logic [1:0] RESP_HOLD   = 2'd2;

    // Navigation status bits
    localparam int unsigned NAV_INERTIAL  = 0;
    localparam int unsigned NAV_ABS_POS   = 1;
    localparam int unsigned NAV_REL_POS   = 2;
    localparam int unsigned NAV_CONST_POS = 3;

    localparam logic [7:0] HEADING_WARN_GAP = 8'd250;
    localparam logic [7:0] BAD_TICKS_MAX    = 8'd255;

    typedef struct packed {
        logic        has_origin;
        logic        motors_armed;
        logic        heading_fault;
        logic        flow_healthy;
        logic [15:0] vel_var;
        logic [15:0] pos_var;
        logic [15:0] mag_var_x;
        logic [15:0] mag_var_y;
        logic [15:0] mag_var_z;
        logic [3:0]  nav_status;
        logic        needs_position;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        variance_bad;
        logic        failsafe_on;
        logic [1:0]  failsafe_change;
        logic [1:0]  response_taken;
        logic        variance_warning;
        logic        heading_warning;
        logic [7:0]  bad_tick_count;
    } t_out_item;

    // Tick after the magnitude squares are summed
    typedef struct packed {
        logic        has_origin;
        logic        motors_armed;
        logic        heading_fault;
        logic        flow_healthy;
        logic [15:0] vel_var;
        logic [15:0] pos_var;
        logic [3:0]  nav_status;
        logic        needs_position;
        logic [31:0] now_ms;
        logic [33:0] mag_sq;
    } t_prep;

    typedef struct packed {
        logic [15:0] threshold;
        logic [31:0] thr_sq;
        logic [1:0]  response;
        logic [7:0]  fail_limit;
        logic [31:0] warn_interval;
    } t_cfg;

endpackage

[rtl/core/efm_prep.sv]
// Input register and compass-variance squaring stage.
module efm_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  efm_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    input  logic              i_down_ready,
    output logic              o_valid,
    output efm_pkg::t_prep    o_prep
);

    logic              r_v1;
    logic              r_v2;
    efm_pkg::t_in_item r_s1;
    efm_pkg::t_prep    r_s2;
    efm_pkg::t_prep    n_s2;
    logic              s1_ready;
    logic              s2_ready;
    logic [31:0]       sq_x;
    logic [31:0]       sq_y;
    logic [31:0]       sq_z;

    assign s2_ready   = !r_v2 || i_down_ready;
    assign s1_ready   = !r_v1 || s2_ready;
    assign o_in_stall = !s1_ready;

    always_comb begin
        sq_x = 32'(r_s1.mag_var_x) * 32'(r_s1.mag_var_x);
        sq_y = 32'(r_s1.mag_var_y) * 32'(r_s1.mag_var_y);
        sq_z = 32'(r_s1.mag_var_z) * 32'(r_s1.mag_var_z);
        n_s2.has_origin     = r_s1.has_origin;
        n_s2.motors_armed   = r_s1.motors_armed;
        n_s2.heading_fault  = r_s1.heading_fault;
        n_s2.flow_healthy   = r_s1.flow_healthy;
        n_s2.vel_var        = r_s1.vel_var;
        n_s2.pos_var        = r_s1.pos_var;
        n_s2.nav_status     = r_s1.nav_status;
        n_s2.needs_position = r_s1.needs_position;
        n_s2.now_ms         = r_s1.now_ms;
        n_s2.mag_sq         = 34'(sq_x) + 34'(sq_y) + 34'(sq_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_in_valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
        if (s1_ready && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (s2_ready && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_prep  = r_s2;

endmodule

[rtl/core/efm_core.sv]
// Threshold scoring, fail counter, failsafe latch, warnings and result register.
module efm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  efm_pkg::t_prep     i_prep,
    input  efm_pkg::t_cfg      i_cfg,
    output logic               o_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output efm_pkg::t_out_item o_out_data
);

    logic               r_out_v;
    efm_pkg::t_out_item r_out;

    logic [7:0]  r_bad_ticks;
    logic        r_bad_flag;
    logic [31:0] r_last_warn;
    logic        r_fs;
    logic [7:0]  r_hwarn_ticks;

    logic [7:0]  n_bad_ticks;
    logic        n_bad_flag;
    logic [31:0] n_last_warn;
    logic        n_fs;
    logic [7:0]  n_hwarn_ticks;
    logic [1:0]  change;
    logic [1:0]  resp;
    logic        vwarn;
    logic        hwarn;

    logic        mag_hit;
    logic        vel_hit;
    logic        pos_hit;
    logic        vel2_hit;
    logic [2:0]  pts;
    logic        pos_ok;
    logic        over;
    logic [7:0]  inc_ticks;
    logic [31:0] since_warn;
    logic        load;

    assign o_ready = !r_out_v || !i_out_stall;
    assign load    = i_valid && o_ready;

    always_comb begin
        mag_hit  = i_prep.mag_sq >= 34'(i_cfg.thr_sq);
        vel_hit  = i_prep.vel_var >= i_cfg.threshold;
        pos_hit  = i_prep.pos_var >= i_cfg.threshold;
        vel2_hit = 17'(i_prep.vel_var) >= {i_cfg.threshold, 1'b0};
        // Velocity scores twice: doubled when flow is unhealthy and far over
        pts = 3'(mag_hit) + 3'(vel_hit) + 3'(pos_hit)
            + ((!i_prep.flow_healthy && vel2_hit) ? 3'd2 : 3'(vel_hit));
        pos_ok = i_prep.nav_status[efm_pkg::NAV_INERTIAL]
              && (i_prep.nav_status[efm_pkg::NAV_ABS_POS]
                  || i_prep.nav_status[efm_pkg::NAV_REL_POS])
              && !i_prep.nav_status[efm_pkg::NAV_CONST_POS];
        over = (pts >= 3'd2) || !pos_ok;

        inc_ticks  = (r_bad_ticks == efm_pkg::BAD_TICKS_MAX) ? r_bad_ticks
                                                             : r_bad_ticks + 8'd1;
        since_warn = i_prep.now_ms - r_last_warn;

        n_bad_ticks   = r_bad_ticks;
        n_bad_flag    = r_bad_flag;
        n_last_warn   = r_last_warn;
        n_fs          = r_fs;
        n_hwarn_ticks = r_hwarn_ticks;
        change        = efm_pkg::CHG_NONE;
        resp          = efm_pkg::RESP_NONE;
        vwarn         = 1'b0;
        hwarn         = 1'b0;

        if (i_prep.has_origin) begin
            if (!i_prep.motors_armed || i_cfg.threshold == 16'd0) begin
                n_bad_ticks = 8'd0;
                n_bad_flag  = 1'b0;
                if (r_fs) begin
                    n_fs   = 1'b0;
                    change = efm_pkg::CHG_CLEAR;
                end
            end else if (over) begin
                if (i_prep.heading_fault) begin
                    n_bad_ticks = 8'd0;
                    n_bad_flag  = 1'b0;
                    if (r_fs) begin
                        n_fs   = 1'b0;
                        change = efm_pkg::CHG_CLEAR;
                    end
                    if (r_hwarn_ticks > efm_pkg::HEADING_WARN_GAP) begin
                        hwarn         = 1'b1;
                        n_hwarn_ticks = 8'd0;
                    end else begin
                        n_hwarn_ticks = r_hwarn_ticks + 8'd1;
                    end
                end else if (!r_bad_flag) begin
                    n_bad_ticks = inc_ticks;
                    if (inc_ticks >= i_cfg.fail_limit) begin
                        n_bad_ticks = i_cfg.fail_limit;
                        n_bad_flag  = 1'b1;
                        if (since_warn > i_cfg.warn_interval) begin
                            vwarn       = 1'b1;
                            n_last_warn = i_prep.now_ms;
                        end
                        if (!r_fs) begin
                            n_fs   = 1'b1;
                            change = efm_pkg::CHG_ENTER;
                            if (i_prep.needs_position) begin
                                case (i_cfg.response)
                                    efm_pkg::FS_RESP_NONE:   resp = efm_pkg::RESP_NONE;
                                    efm_pkg::FS_RESP_REPORT: resp = efm_pkg::RESP_REPORT;
                                    default:                 resp = efm_pkg::RESP_HOLD;
                                endcase
                            end
                        end
                    end
                end
            end else if (r_bad_ticks != 8'd0) begin
                n_bad_ticks = r_bad_ticks - 8'd1;
                if (r_bad_flag && n_bad_ticks == 8'd0) begin
                    n_bad_flag = 1'b0;
                    if (r_fs) begin
                        n_fs   = 1'b0;
                        change = efm_pkg::CHG_CLEAR;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v       <= 1'b0;
            r_bad_ticks   <= 8'd0;
            r_bad_flag    <= 1'b0;
            r_last_warn   <= 32'd0;
            r_fs          <= 1'b0;
            r_hwarn_ticks <= 8'd0;
        end else begin
            if (o_ready) begin
                r_out_v <= i_valid;
            end
            if (load) begin
                r_bad_ticks   <= n_bad_ticks;
                r_bad_flag    <= n_bad_flag;
                r_last_warn   <= n_last_warn;
                r_fs          <= n_fs;
                r_hwarn_ticks <= n_hwarn_ticks;
            end
        end
        if (load) begin
            r_out.variance_bad     <= n_bad_flag;
            r_out.failsafe_on      <= n_fs;
            r_out.failsafe_change  <= change;
            r_out.response_taken   <= resp;
            r_out.variance_warning <= vwarn;
            r_out.heading_warning  <= hwarn;
            r_out.bad_tick_count   <= n_bad_ticks;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

[rtl/core/ekf_variance_failsafe_monitor.sv]
// Top level of the estimator variance failsafe monitor.
//
// Usage:
//   One input transaction per estimator tick carries the variances, arming,
//   origin, heading-fault, flow and navigation status flags plus the time.
//   Each accepted transaction yields exactly one result transaction with the
//   bad-variance flag, failsafe state and change, the response taken, the
//   two throttled warnings and the fail counter.
//   Both channels use valid/stall; a transaction moves on a rising edge with
//   valid high and stall low.
// Pipeline and throughput:
//   Three register stages (input, square-sum, result). One transaction per
//   cycle is sustained while the receiver does not stall; the square-sum
//   stage holds the three 16x16 multipliers and the result stage holds the
//   compares and the state update.
// Reset (synchronous, active low): empties all stages, clears the fail
//   counter, flags, warning timer and heading counter, and loads the
//   configuration defaults. The user writes configuration only while idle; the block does not enforce it.
// Receiver stall: the result register holds; the earlier stages keep
//   filling until full, then input stall rises.
module ekf_variance_failsafe_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  efm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output efm_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata
);

    efm_pkg::t_cfg  r_cfg;
    efm_pkg::t_prep prep;
    logic           prep_valid;
    logic           core_ready;

    // Configuration registers; keep the squared threshold alongside it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= efm_pkg::RST_THRESHOLD;
            r_cfg.thr_sq        <= efm_pkg::RST_THR_SQ;
            r_cfg.response      <= efm_pkg::RST_RESPONSE;
            r_cfg.fail_limit    <= efm_pkg::RST_FAIL_LIMIT;
            r_cfg.warn_interval <= efm_pkg::RST_WARN_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                efm_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold <= i_cfg_wdata[15:0];
                    r_cfg.thr_sq    <= 32'(i_cfg_wdata[15:0]) * 32'(i_cfg_wdata[15:0]);
                end
                efm_pkg::CFG_RESPONSE:      r_cfg.response      <= i_cfg_wdata[1:0];
                efm_pkg::CFG_FAIL_LIMIT:    r_cfg.fail_limit    <= i_cfg_wdata[7:0];
                efm_pkg::CFG_WARN_INTERVAL: r_cfg.warn_interval <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register and magnitude square-sum
    efm_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_down_ready (core_ready),
        .o_valid      (prep_valid),
        .o_prep       (prep)
    );

    // Scoring, counters, failsafe latch and result register
    efm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (prep_valid),
        .i_prep      (prep),
        .i_cfg       (r_cfg),
        .o_ready     (core_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[dv/testbench.sv]
// Self-checking testbench for the estimator variance failsafe monitor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth from the top-level notes; used for settling waits only.
    localparam int LATENCY        = 3;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int PHASE_TICKS    = 90;

    // Shape of a generated tick: calm, over threshold, over threshold with a
    // heading fault, or fully random fields.
    typedef enum int {KIND_GOOD, KIND_BAD, KIND_HEADING, KIND_NOISE} tick_kind_e;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    efm_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    efm_pkg::t_out_item o_out_data;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_wdata;

    ekf_variance_failsafe_monitor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 10 ns clock; starts low so no rising edge falls on time zero.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the block's registers and counters
    // ------------------------------------------------------------------
    logic [15:0] m_thr;
    logic [1:0]  m_resp;
    logic [7:0]  m_limit;
    logic [31:0] m_interval;

    logic [7:0]  m_bad_ticks;
    logic        m_bad_flag;
    logic [31:0] m_last_warn;
    logic        m_fs_latched;
    logic [7:0]  m_hdg_ticks;

    efm_pkg::t_out_item expected_results[$];

    // Bookkeeping for the run summary and the verdict
    int          ticks_sent      = 0;
    int          results_checked = 0;
    int          errors          = 0;
    int          settings_used   = 0;
    int          fs_entries      = 0;
    int          var_warnings    = 0;
    int          hdg_warnings    = 0;
    int          cycle_count     = 0;

    // Stimulus shaping
    int          send_idle_pct   = 0;
    int          stall_pct;
    logic [31:0] clock_ms;
    logic        holdoff_req  = 1'b0;
    logic        holdoff_seen = 1'b0;
    int          holdoff_left = 0;

    // Load reset defaults into the predictor.
    task automatic reset_predictor();
        m_thr        = efm_pkg::RST_THRESHOLD;
        m_resp       = efm_pkg::RST_RESPONSE;
        m_limit      = efm_pkg::RST_FAIL_LIMIT;
        m_interval   = efm_pkg::RST_WARN_INTERVAL;
        m_bad_ticks  = '0;
        m_bad_flag   = 1'b0;
        m_last_warn  = '0;
        m_fs_latched = 1'b0;
        m_hdg_ticks  = '0;
    endtask

    // Decide whether a tick is over threshold. Magnitude is compared as a sum
    // of squares against the squared threshold, exactly. The velocity
    // variance scores twice: once on its own and once more (or two more with
    // unhealthy flow and at least twice the threshold).
    function automatic logic over_limit(input efm_pkg::t_in_item t);
        longint unsigned mag_sq;
        longint unsigned thr;
        int              pts;
        logic            pos_ok;
        thr    = m_thr;
        pts    = 0;
        if (thr == 0)
            return 1'b0;
        mag_sq = longint'(t.mag_var_x) * t.mag_var_x + longint'(t.mag_var_y) * t.mag_var_y
               + longint'(t.mag_var_z) * t.mag_var_z;
        if (mag_sq >= thr * thr) pts++;
        if (t.vel_var >= thr) pts++;
        if (t.pos_var >= thr) pts++;
        if (!t.flow_healthy && t.vel_var >= 2 * thr)
            pts += 2;
        else if (t.vel_var >= thr)
            pts++;
        if (pts >= 2)
            return 1'b1;
        pos_ok = t.nav_status[efm_pkg::NAV_INERTIAL]
              && (t.nav_status[efm_pkg::NAV_ABS_POS] || t.nav_status[efm_pkg::NAV_REL_POS])
              && !t.nav_status[efm_pkg::NAV_CONST_POS];
        return !pos_ok;
    endfunction

    // Drop the failsafe latch, returning the change code it causes.
    function automatic logic [1:0] drop_failsafe();
        if (!m_fs_latched)
            return efm_pkg::CHG_NONE;
        m_fs_latched = 1'b0;
        return efm_pkg::CHG_CLEAR;
    endfunction

    // Advance the predictor by one accepted tick and return its result.
    function automatic efm_pkg::t_out_item predict_failsafe(input efm_pkg::t_in_item t);
        efm_pkg::t_out_item r;
        logic [31:0]        since_warn;
        r                 = '0;
        r.failsafe_change = efm_pkg::CHG_NONE;
        r.response_taken  = efm_pkg::RESP_NONE;
        if (t.has_origin) begin
            if (!t.motors_armed || m_thr == 0) begin
                // Disarmed or checking disabled: clear everything
                m_bad_ticks       = '0;
                m_bad_flag        = 1'b0;
                r.failsafe_change = drop_failsafe();
            end else if (over_limit(t)) begin
                if (t.heading_fault) begin
                    // Blame the heading source, not the estimator
                    m_bad_ticks       = '0;
                    m_bad_flag        = 1'b0;
                    r.failsafe_change = drop_failsafe();
                    if (m_hdg_ticks > efm_pkg::HEADING_WARN_GAP) begin
                        r.heading_warning = 1'b1;
                        m_hdg_ticks       = '0;
                        hdg_warnings++;
                    end else begin
                        m_hdg_ticks = m_hdg_ticks + 8'd1;
                    end
                end else if (!m_bad_flag) begin
                    if (m_bad_ticks != efm_pkg::BAD_TICKS_MAX)
                        m_bad_ticks = m_bad_ticks + 8'd1;
                    if (m_bad_ticks >= m_limit) begin
                        m_bad_ticks = m_limit;
                        m_bad_flag  = 1'b1;
                        since_warn  = t.now_ms - m_last_warn;
                        if (since_warn > m_interval) begin
                            r.variance_warning = 1'b1;
                            m_last_warn        = t.now_ms;
                            var_warnings++;
                        end
                        if (!m_fs_latched) begin
                            m_fs_latched      = 1'b1;
                            r.failsafe_change = efm_pkg::CHG_ENTER;
                            fs_entries++;
                            if (t.needs_position)
                                r.response_taken =
                                    (m_resp == efm_pkg::FS_RESP_NONE)   ? efm_pkg::RESP_NONE
                                  : (m_resp == efm_pkg::FS_RESP_REPORT) ? efm_pkg::RESP_REPORT
                                  : efm_pkg::RESP_HOLD;
                        end
                    end
                end
            end else if (m_bad_ticks != 0) begin
                // Good tick: count down, and release once the counter empties
                m_bad_ticks = m_bad_ticks - 8'd1;
                if (m_bad_flag && m_bad_ticks == 0) begin
                    m_bad_flag        = 1'b0;
                    r.failsafe_change = drop_failsafe();
                end
            end
        end
        r.variance_bad   = m_bad_flag;
        r.failsafe_on    = m_fs_latched;
        r.bad_tick_count = m_bad_ticks;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h",
                 results_checked, what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Sample at the rising edge: the values seen here are the ones the edge
    // acts on, so each accepted result is compared with the oldest
    // expectation.
    always @(posedge i_clk) begin : check_results
        efm_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_out_data, 0);
            end else begin
                want = expected_results.pop_front();
                check_field("variance_bad", o_out_data.variance_bad, want.variance_bad);
                check_field("failsafe_on", o_out_data.failsafe_on, want.failsafe_on);
                check_field("failsafe_change", o_out_data.failsafe_change,
                            want.failsafe_change);
                check_field("response_taken", o_out_data.response_taken,
                            want.response_taken);
                check_field("variance_warning", o_out_data.variance_warning,
                            want.variance_warning);
                check_field("heading_warning", o_out_data.heading_warning,
                            want.heading_warning);
                check_field("bad_tick_count", o_out_data.bad_tick_count,
                            want.bad_tick_count);
            end
            results_checked++;
        end
    end

    // Receiver side: random stall per cycle, or a long hold-off when the test
    // toggles its request. Count the hold-off here so it runs on its own
    // while the sender keeps offering ticks.
    always @(posedge i_clk) begin
        if (holdoff_req != holdoff_seen) begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            i_out_stall  <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one tick and hold it until the transaction completes, then
    // record its prediction. Leave the input idle on a per-cycle draw.
    task automatic send_tick(input efm_pkg::t_in_item t);
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_failsafe(t));
        ticks_sent++;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every pending result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Drain, then let the pipeline settle before touching registers.
    task automatic settle();
        wait_for_results();
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Write one register; drop the enable for a cycle so back-to-back
    // writes never raise and lower it in the same step.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (index)
            efm_pkg::CFG_THRESHOLD:     m_thr      = value[15:0];
            efm_pkg::CFG_RESPONSE:      m_resp     = value[1:0];
            efm_pkg::CFG_FAIL_LIMIT:    m_limit    = value[7:0];
            efm_pkg::CFG_WARN_INTERVAL: m_interval = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [1:0] resp,
                                  input logic [7:0] limit, input logic [31:0] interval);
        settle();
        write_reg(efm_pkg::CFG_THRESHOLD, {16'd0, thr});
        write_reg(efm_pkg::CFG_RESPONSE, {30'd0, resp});
        write_reg(efm_pkg::CFG_FAIL_LIMIT, {24'd0, limit});
        write_reg(efm_pkg::CFG_WARN_INTERVAL, interval);
        settings_used++;
    endtask

    // Idle modes: none, sender gaps, receiver stalls, both.
    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 61; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 61; end
            default: begin send_idle_pct = 33; stall_pct <= 33; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tick generation
    // ------------------------------------------------------------------

    // Armed, origin set, all variances zero, position ok: a calm tick.
    function automatic efm_pkg::t_in_item calm_tick(input logic [31:0] now);
        efm_pkg::t_in_item t;
        t                                   = '0;
        t.has_origin                        = 1'b1;
        t.motors_armed                      = 1'b1;
        t.flow_healthy                      = 1'b1;
        t.nav_status[efm_pkg::NAV_INERTIAL] = 1'b1;
        t.nav_status[efm_pkg::NAV_ABS_POS]  = 1'b1;
        t.needs_position                    = 1'b1;
        t.now_ms                            = now;
        return t;
    endfunction

    // Pick a variance clustered around the compare points of the threshold.
    function automatic logic [15:0] near_thr();
        logic [16:0] dbl;
        dbl = {1'b0, m_thr} << 1;
        case ($urandom_range(8, 0))
            0: return 16'd0;
            1: return 16'($urandom_range(m_thr, 0));
            2: return m_thr - 16'd1;
            3: return m_thr;
            4: return m_thr + 16'd1;
            5: return (dbl > 17'h0FFFF) ? 16'hFFFF : dbl[15:0] - 16'd1;
            6: return (dbl > 17'h0FFFF) ? 16'hFFFF : dbl[15:0];
            7: return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic efm_pkg::t_in_item make_tick(input tick_kind_e kind);
        efm_pkg::t_in_item t;
        logic [127:0]      raw;
        clock_ms           = clock_ms + $urandom_range(20000, 0);
        t                  = calm_tick(clock_ms);
        t.flow_healthy     = 1'($urandom_range(1, 0));
        t.needs_position   = 1'($urandom_range(1, 0));
        t.vel_var          = near_thr();
        t.pos_var          = near_thr();
        t.mag_var_x        = near_thr();
        t.mag_var_y        = near_thr();
        t.mag_var_z        = near_thr();
        t.nav_status       = 4'($urandom);
        case (kind)
            KIND_GOOD: begin
                // Keep every score at or below one and the position ok
                t.heading_fault = 1'($urandom_range(1, 0));
                t.mag_var_x     = 16'($urandom_range(m_thr >> 1, 0));
                t.mag_var_y     = 16'($urandom_range(m_thr >> 1, 0));
                t.mag_var_z     = 16'($urandom_range(m_thr >> 1, 0));
                t.vel_var       = (m_thr == 0) ? 16'd0
                                               : 16'($urandom_range(m_thr - 16'd1, 0));
                t.nav_status    = '0;
                t.nav_status[efm_pkg::NAV_INERTIAL] = 1'b1;
                t.nav_status[efm_pkg::NAV_ABS_POS]  = 1'($urandom_range(1, 0));
                if (!t.nav_status[efm_pkg::NAV_ABS_POS])
                    t.nav_status[efm_pkg::NAV_REL_POS] = 1'b1;
                else
                    t.nav_status[efm_pkg::NAV_REL_POS] = 1'($urandom_range(1, 0));
            end
            KIND_BAD, KIND_HEADING: begin
                // Spoil the position estimate most of the time
                case ($urandom_range(3, 0))
                    0: t.nav_status[efm_pkg::NAV_INERTIAL] = 1'b0;
                    1: t.nav_status[efm_pkg::NAV_CONST_POS] = 1'b1;
                    2: t.nav_status[efm_pkg::NAV_REL_POS:efm_pkg::NAV_ABS_POS] = 2'b00;
                    default: ;
                endcase
                t.heading_fault = (kind == KIND_HEADING);
            end
            default: begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                t   = raw[$bits(efm_pkg::t_in_item)-1:0];
            end
        endcase
        return t;
    endfunction

    task automatic send_run(input tick_kind_e kind, input int len);
        repeat (len) send_tick(make_tick(kind));
    endtask

    // Mostly well-formed campaigns: climb to the fail limit then recover,
    // heading-fault stretches, and some noise and mixed ticks in between.
    task automatic run_random(input int count);
        int target;
        int len;
        int roll;
        target = ticks_sent + count;
        while (ticks_sent < target) begin
            if ($urandom_range(3, 0) == 0)
                set_idle($urandom_range(3, 0));
            roll = $urandom_range(99, 0);
            if (roll < 40) begin
                len = m_limit + $urandom_range(3, 0);
                send_run(KIND_BAD, (len > 30) ? 30 : len);
                len = $urandom_range(m_limit + 3, 1);
                send_run(KIND_GOOD, (len > 30) ? 30 : len);
            end else if (roll < 70) begin
                send_run(KIND_HEADING, $urandom_range(40, 10));
            end else if (roll < 85) begin
                send_run(KIND_NOISE, $urandom_range(8, 1));
            end else begin
                len = $urandom_range(10, 1);
                repeat (len) send_tick(make_tick(tick_kind_e'($urandom_range(3, 0))));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk the reset configuration through each branch: no origin,
    // disarmed, heading fault, every scoring path and its boundary, the
    // climb to the fail limit with entry, warning and hold, a count-down and
    // a disarm that clears.
    task automatic test_directed();
        efm_pkg::t_in_item t;
        set_idle(0);
        t = calm_tick(32'd1000);     t.has_origin = 1'b0; t.vel_var = 16'hFFFF;
        send_tick(t);
        t = calm_tick(32'd2000);     t.motors_armed = 1'b0;
        send_tick(t);
        t = calm_tick(32'd3000);     t.vel_var = 16'hFFFF; t.heading_fault = 1'b1;
        send_tick(t);
        t = calm_tick(32'd4000);
        send_tick(t);
        // Every variance at full scale, flow bad, all status bits set
        t = '1;                      t.now_ms = 32'd5000; t.flow_healthy = 1'b0;
        send_tick(t);
        // Magnitude exactly at the squared threshold plus position at it
        t = calm_tick(32'd6000);
        t.mag_var_x = efm_pkg::RST_THRESHOLD;
        t.pos_var   = efm_pkg::RST_THRESHOLD;
        send_tick(t);
        t = calm_tick(32'd7000);     t.mag_var_z = efm_pkg::RST_THRESHOLD - 16'd1;
        t.pos_var = efm_pkg::RST_THRESHOLD;
        send_tick(t);
        t = calm_tick(32'd8000);     t.vel_var = efm_pkg::RST_THRESHOLD << 1;
        t.flow_healthy = 1'b0;
        send_tick(t);
        t = calm_tick(32'd9000);     t.vel_var = (efm_pkg::RST_THRESHOLD << 1) - 16'd1;
        t.flow_healthy = 1'b0;
        send_tick(t);
        t = calm_tick(32'd10000);    t.vel_var = efm_pkg::RST_THRESHOLD;
        send_tick(t);
        t = calm_tick(32'd11000);    t.vel_var = efm_pkg::RST_THRESHOLD - 16'd1;
        send_tick(t);
        t = calm_tick(32'd12000);    t.nav_status = 4'b0000;
        send_tick(t);
        t = calm_tick(32'd13000);    t.nav_status = 4'b1011;
        send_tick(t);
        t = calm_tick(32'd14000);    t.nav_status = 4'b0001;
        send_tick(t);
        t = calm_tick(32'd15000);    t.nav_status = 4'b0101;
        send_tick(t);
        // Climb the rest of the way; entry comes with a warning and hold
        for (int i = 0; i < 5; i++) begin
            t = calm_tick(32'd50000 + i); t.nav_status = 4'b0000;
            send_tick(t);
        end
        t = calm_tick(32'd60000);    t.vel_var = 16'hFFFF;
        send_tick(t);
        t = calm_tick(32'd61000);
        send_tick(t);
        t = calm_tick(32'd62000);    t.motors_armed = 1'b0;
        send_tick(t);
    endtask

    // Run random campaigns under several register settings, the extremes
    // among them: checking disabled, the tightest and loosest thresholds,
    // a zero fail limit, the unused response code and the interval bounds.
    task automatic test_config_sweep();
        logic [15:0] thr_set      [8] = '{16'd205, 16'd1, 16'hFFFF, 16'd0,
                                          16'd1000, 16'h8000, 16'd300, 16'd150};
        logic [1:0]  resp_set     [8] = '{efm_pkg::FS_RESP_HOLD, efm_pkg::FS_RESP_REPORT,
                                          efm_pkg::FS_RESP_NONE, efm_pkg::FS_RESP_HOLD,
                                          efm_pkg::FS_RESP_SPARE, efm_pkg::FS_RESP_HOLD,
                                          efm_pkg::FS_RESP_REPORT, efm_pkg::FS_RESP_NONE};
        logic [7:0]  limit_set    [8] = '{8'd10, 8'd1, 8'd255, 8'd5, 8'd0, 8'd3, 8'd4, 8'd6};
        logic [31:0] interval_set [8] = '{32'd30000, 32'd0, 32'hFFFF_FFFF, 32'd1000,
                                          32'd5000, 32'd20000, 32'd100, 32'd30000};
        for (int p = 0; p < 8; p++) begin
            apply_settings(thr_set[p], resp_set[p], limit_set[p], interval_set[p]);
            if (p == 2)
                clock_ms = 32'hFFFF_0000;   // let the time wrap in this phase
            set_idle(p % 4);
            run_random(PHASE_TICKS);
        end
    endtask

    // Hold the receiver off for a long stretch while ticks keep coming, so
    // the pipeline fills and pushes back on its input.
    task automatic test_backpressure();
        apply_settings(16'd205, efm_pkg::FS_RESP_HOLD, 8'd2, 32'd500);
        set_idle(0);
        holdoff_req <= ~holdoff_req;
        run_random(40);
    endtask

    // Pause the sender mid-stream until every result is back, then resume.
    task automatic test_pause();
        set_idle(3);
        run_random(20);
        wait_for_results();
        run_random(20);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= efm_pkg::CFG_THRESHOLD;
        i_cfg_wdata <= '0;
        stall_pct   <= 0;
        clock_ms     = $urandom;
        reset_predictor();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_pause();

        settle();
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("summary: %0d ticks over %0d register settings, %0d results compared",
                 ticks_sent, settings_used, results_checked);
        $display("summary: %0d failsafe entries, %0d variance and %0d heading warnings",
                 fs_entries, var_warnings, hdg_warnings);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
